// ----- hw/rtl/wsel_pkg.sv -----
`timescale 1ns / 1ps

package wsel_pkg;

  localparam int WEIGHT_W = 16;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_SORTED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // What a list cell loads at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT,
    CELL_TAKE_HEAD
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

endpackage

// ----- hw/rtl/weight_sorted_edge_list.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Beat contents
// in       into       in_valid/in_stall   mode, edge_weight, dest_vertex
// out      out of     out_valid/out_stall out_weight, out_dest, entry_count, status, last_of_run
//
// Insert, clear and other modes each give one beat; with the
// output taken every cycle a new item is accepted every cycle.
// Read out gives one beat per held entry: the cell
// chain rotates by one position per beat, with the head cell feeding the output,
// and input is stalled until the last entry has left; the rotation leaves the
// list as it was.
// Reset clears the held-entry count, the sequencer and the output valid; cell
// contents and the other output fields are not reset. A stalled output beat holds and stalls the input.

module weight_sorted_edge_list #(
  parameter int CAPACITY     = 32,
  parameter int VERTEX_COUNT = 1024,
  localparam int DEST_W      = $clog2(VERTEX_COUNT),
  localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wsel_pkg::MODE_W-1:0]          mode,
  input  logic signed [wsel_pkg::WEIGHT_W-1:0] edge_weight,
  input  logic [DEST_W-1:0]                    dest_vertex,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wsel_pkg::WEIGHT_W-1:0] out_weight,
  output logic [DEST_W-1:0]                    out_dest,
  output logic [CNT_W-1:0]                     entry_count,
  output logic [wsel_pkg::STATUS_W-1:0]        status,
  output logic                                 last_of_run
);

  wsel_pkg::state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_left;

  logic signed [wsel_pkg::WEIGHT_W-1:0] cell_w [CAPACITY];
  logic [DEST_W-1:0]                    cell_d [CAPACITY];
  logic [CAPACITY-1:0]                  cell_gt;
  wsel_pkg::cell_op_t                   cell_op [CAPACITY];

  logic                out_free;
  logic                acc;
  logic                full;
  logic [CAPACITY-1:0] gt;
  logic                any_gt;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != wsel_pkg::ST_IDLE) || !out_free;
  assign acc      = in_valid && !in_stall;
  assign full     = count == CNT_W'(CAPACITY);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = cell_gt[i] && (CNT_W'(i) < count);
    end
  end
  assign any_gt = |gt;

  // Per-cell move decode. A sorted insert lands in front of the first held
  // entry heavier than the new edge; everything behind it moves one place down.
  always_comb begin
    logic ahead;
    for (int i = 0; i < CAPACITY; i++) begin
      ahead      = |(gt & ~({CAPACITY{1'b1}} << i));
      cell_op[i] = wsel_pkg::CELL_HOLD;
      if (state == wsel_pkg::ST_READ) begin
        if (out_free) begin
          cell_op[i] = (CNT_W'(i) == count - CNT_W'(1)) ? wsel_pkg::CELL_TAKE_HEAD
                                                         : wsel_pkg::CELL_TAKE_NEXT;
        end
      end else if (acc && !full) begin
        case (mode)
          wsel_pkg::MODE_SORTED: begin
            if (ahead) begin
              cell_op[i] = wsel_pkg::CELL_TAKE_PREV;
            end else if (gt[i] || (!any_gt && CNT_W'(i) == count)) begin
              cell_op[i] = wsel_pkg::CELL_LOAD_NEW;
            end
          end
          wsel_pkg::MODE_HEAD: begin
            cell_op[i] = (i == 0) ? wsel_pkg::CELL_LOAD_NEW : wsel_pkg::CELL_TAKE_PREV;
          end
          wsel_pkg::MODE_TAIL: begin
            if (CNT_W'(i) == count) begin
              cell_op[i] = wsel_pkg::CELL_LOAD_NEW;
            end
          end
          default: cell_op[i] = wsel_pkg::CELL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == CAPACITY - 1) ? 0 : g + 1;

    wsel_cell #(
      .DEST_W(DEST_W)
    ) u_cell (
      .clk    (clk),
      .op     (cell_op[g]),
      .new_w  (edge_weight),
      .new_d  (dest_vertex),
      .prev_w (cell_w[PREV]),
      .prev_d (cell_d[PREV]),
      .next_w (cell_w[NEXT]),
      .next_d (cell_d[NEXT]),
      .head_w (cell_w[0]),
      .head_d (cell_d[0]),
      .w      (cell_w[g]),
      .d      (cell_d[g]),
      .gt     (cell_gt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsel_pkg::ST_IDLE;
      count     <= '0;
      rd_left   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        wsel_pkg::ST_IDLE: begin
          if (acc) begin
            out_weight  <= '0;
            out_dest    <= '0;
            last_of_run <= 1'b1;
            case (mode) inside
              wsel_pkg::MODE_SORTED, wsel_pkg::MODE_HEAD, wsel_pkg::MODE_TAIL: begin
                out_valid <= 1'b1;
                if (full) begin
                  status      <= wsel_pkg::STATUS_FULL;
                  entry_count <= count;
                end else begin
                  status      <= wsel_pkg::STATUS_OK;
                  count       <= count + CNT_W'(1);
                  entry_count <= count + CNT_W'(1);
                end
              end
              wsel_pkg::MODE_READ: begin
                if (count == '0) begin
                  out_valid   <= 1'b1;
                  status      <= wsel_pkg::STATUS_EMPTY;
                  entry_count <= count;
                end else begin
                  // Entries are streamed from the read state.
                  out_valid <= 1'b0;
                  rd_left   <= count;
                  state     <= wsel_pkg::ST_READ;
                end
              end
              wsel_pkg::MODE_CLEAR: begin
                out_valid   <= 1'b1;
                status      <= wsel_pkg::STATUS_OK;
                count       <= '0;
                entry_count <= '0;
              end
              default: begin
                out_valid   <= 1'b1;
                status      <= wsel_pkg::STATUS_OK;
                entry_count <= count;
              end
            endcase
          end else if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        wsel_pkg::ST_READ: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_weight  <= cell_w[0];
            out_dest    <= cell_d[0];
            entry_count <= count;
            status      <= wsel_pkg::STATUS_OK;
            last_of_run <= rd_left == CNT_W'(1);
            rd_left     <= rd_left - CNT_W'(1);
            if (rd_left == CNT_W'(1)) begin
              state <= wsel_pkg::ST_IDLE;
            end
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_read_left: assert property (@(posedge clk) disable iff (rst)
    state == wsel_pkg::ST_READ |-> rd_left != '0 && rd_left <= count)
    else $error("read-out counter out of range");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    acc && full && (mode == wsel_pkg::MODE_SORTED || mode == wsel_pkg::MODE_HEAD ||
                    mode == wsel_pkg::MODE_TAIL)
    |=> count == $past(count) && status == wsel_pkg::STATUS_FULL)
    else $error("insert into full list changed the list");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == wsel_pkg::STATUS_EMPTY |-> entry_count == '0 && last_of_run)
    else $error("empty beat with nonzero count");

endmodule

// ----- hw/rtl/wsel_cell.sv -----
`timescale 1ns / 1ps

module wsel_cell #(
  parameter int DEST_W = 10
) (
  input  logic                                 clk,
  input  wsel_pkg::cell_op_t                   op,
  input  logic signed [wsel_pkg::WEIGHT_W-1:0] new_w,
  input  logic        [DEST_W-1:0]             new_d,
  input  logic signed [wsel_pkg::WEIGHT_W-1:0] prev_w,
  input  logic        [DEST_W-1:0]             prev_d,
  input  logic signed [wsel_pkg::WEIGHT_W-1:0] next_w,
  input  logic        [DEST_W-1:0]             next_d,
  input  logic signed [wsel_pkg::WEIGHT_W-1:0] head_w,
  input  logic        [DEST_W-1:0]             head_d,
  output logic signed [wsel_pkg::WEIGHT_W-1:0] w,
  output logic        [DEST_W-1:0]             d,
  output logic                                 gt
);

  assign gt = w > new_w;

  always_ff @(posedge clk) begin
    unique case (op)
      wsel_pkg::CELL_HOLD: begin
        w <= w;
        d <= d;
      end
      wsel_pkg::CELL_LOAD_NEW: begin
        w <= new_w;
        d <= new_d;
      end
      wsel_pkg::CELL_TAKE_PREV: begin
        w <= prev_w;
        d <= prev_d;
      end
      wsel_pkg::CELL_TAKE_NEXT: begin
        w <= next_w;
        d <= next_d;
      end
      wsel_pkg::CELL_TAKE_HEAD: begin
        w <= head_w;
        d <= head_d;
      end
    endcase
  end

endmodule

// ----- verif/weight_sorted_edge_list_tb.sv -----
`timescale 1ns / 1ps

module weight_sorted_edge_list_tb;

  localparam int LIST_DEPTH   = 32;
  localparam int VERTICES     = 1024;
  localparam int DEST_W       = $clog2(VERTICES);
  localparam int CNT_W        = $clog2(LIST_DEPTH + 1);
  localparam int TOTAL_OPS    = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  // Modes the block ignores apart from a plain acknowledgement.
  localparam logic [wsel_pkg::MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [wsel_pkg::MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [wsel_pkg::MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  typedef struct {
    logic signed [wsel_pkg::WEIGHT_W-1:0] weight;
    logic [DEST_W-1:0]                    dest;
    logic [CNT_W-1:0]                     count;
    logic [wsel_pkg::STATUS_W-1:0]        status;
    logic                                 last;
  } list_beat_t;

  typedef struct {
    logic [wsel_pkg::MODE_W-1:0]          op;
    logic signed [wsel_pkg::WEIGHT_W-1:0] w;
    logic [DEST_W-1:0]                    v;
    bit                                   fixed;
    logic [CNT_W-1:0]                     cnt;
    logic [wsel_pkg::STATUS_W-1:0]        st;
  } dir_row_t;

  localparam int DIR_ROWS = 21;

  // Rows marked fixed carry the single acknowledgement typed in by hand;
  // the others are checked against the list model below.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{wsel_pkg::MODE_READ,   16'sd0,     10'd0,    1'b1, 6'd0, wsel_pkg::STATUS_EMPTY},
    '{wsel_pkg::MODE_CLEAR,  16'sd0,     10'd0,    1'b1, 6'd0, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_SORTED, 16'sd0,     10'd5,    1'b1, 6'd1, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_SORTED, 16'sh7fff,  10'd1023, 1'b1, 6'd2, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_SORTED, 16'sh8000,  10'd0,    1'b1, 6'd3, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_SORTED, 16'sd0,     10'd6,    1'b1, 6'd4, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_SORTED, -16'sd1,    10'd512,  1'b1, 6'd5, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_HEAD,   16'sd1,     10'd7,    1'b1, 6'd6, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_TAIL,   -16'sd2,    10'd8,    1'b1, 6'd7, wsel_pkg::STATUS_OK},
    '{MODE_UNUSED_5,         -16'sd1,    10'd1023, 1'b1, 6'd7, wsel_pkg::STATUS_OK},
    '{MODE_UNUSED_7,         16'sh7fff,  10'd341,  1'b1, 6'd7, wsel_pkg::STATUS_OK},
    '{MODE_UNUSED_6,         16'sh8000,  10'd682,  1'b1, 6'd7, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_READ,   16'sd0,     10'd0,    1'b0, 6'd0, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_SORTED, 16'sh7fff,  10'd9,    1'b1, 6'd8, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_HEAD,   16'sh8000,  10'd1,    1'b1, 6'd9, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_READ,   -16'sd1,    10'd1023, 1'b0, 6'd0, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_CLEAR,  16'sh7fff,  10'd1023, 1'b1, 6'd0, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_READ,   16'sd0,     10'd0,    1'b1, 6'd0, wsel_pkg::STATUS_EMPTY},
    '{wsel_pkg::MODE_TAIL,   16'sd12345, 10'd300,  1'b1, 6'd1, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_READ,   16'sd0,     10'd0,    1'b0, 6'd0, wsel_pkg::STATUS_OK},
    '{wsel_pkg::MODE_CLEAR,  16'sd0,     10'd0,    1'b1, 6'd0, wsel_pkg::STATUS_OK}
  };

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [wsel_pkg::MODE_W-1:0]          mode;
  logic signed [wsel_pkg::WEIGHT_W-1:0] edge_weight;
  logic [DEST_W-1:0]                    dest_vertex;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [wsel_pkg::WEIGHT_W-1:0] out_weight;
  logic [DEST_W-1:0]                    out_dest;
  logic [CNT_W-1:0]                     entry_count;
  logic [wsel_pkg::STATUS_W-1:0]        status;
  logic                                 last_of_run;

  weight_sorted_edge_list #(
    .CAPACITY     (LIST_DEPTH),
    .VERTEX_COUNT (VERTICES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .edge_weight (edge_weight),
    .dest_vertex (dest_vertex),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_weight  (out_weight),
    .out_dest    (out_dest),
    .entry_count (entry_count),
    .status      (status),
    .last_of_run (last_of_run)
  );

  // Model of the list contents, head at index 0.
  logic signed [wsel_pkg::WEIGHT_W-1:0] edge_w [LIST_DEPTH];
  logic [DEST_W-1:0]                    edge_v [LIST_DEPTH];
  int                                   held;

  list_beat_t expected_beats [$];

  int  errors;
  int  ops_sent;
  int  beats_checked;
  int  full_hits;
  int  readouts;
  int  max_held;
  int  long_holds;
  int  cycle_count;
  int  send_calm;
  int  recv_calm;
  bit  hold_request;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Narrow weights make ties common so arrival order gets exercised.
  function automatic logic signed [wsel_pkg::WEIGHT_W-1:0] pick_weight();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      v = $urandom_range(0, 8) - 4;
      return v[wsel_pkg::WEIGHT_W-1:0];
    end
    if (r == 3) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic logic [wsel_pkg::MODE_W-1:0] pick_insert_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return wsel_pkg::MODE_SORTED;
    if (r < 85) return wsel_pkg::MODE_HEAD;
    return wsel_pkg::MODE_TAIL;
  endfunction

  // Updates the list model for one accepted operation and, when keep is set,
  // queues the beats it should produce.
  function automatic void apply_edge_op(input logic [wsel_pkg::MODE_W-1:0] op,
                                        input logic signed [wsel_pkg::WEIGHT_W-1:0] w,
                                        input logic [DEST_W-1:0] v,
                                        input bit keep);
    list_beat_t b;
    int pos;
    b = '{weight: '0, dest: '0, count: '0, status: wsel_pkg::STATUS_OK, last: 1'b1};
    ops_sent++;
    if (op == wsel_pkg::MODE_SORTED || op == wsel_pkg::MODE_HEAD ||
        op == wsel_pkg::MODE_TAIL) begin
      if (held >= LIST_DEPTH) begin
        full_hits++;
        b.status = wsel_pkg::STATUS_FULL;
      end else begin
        pos = held;
        if (op == wsel_pkg::MODE_HEAD) begin
          pos = 0;
        end else if (op == wsel_pkg::MODE_SORTED) begin
          for (int i = 0; i < held; i++) begin
            if (edge_w[i] > w) begin
              pos = i;
              break;
            end
          end
        end
        for (int i = held; i > pos; i--) begin
          edge_w[i] = edge_w[i-1];
          edge_v[i] = edge_v[i-1];
        end
        edge_w[pos] = w;
        edge_v[pos] = v;
        held++;
        if (held > max_held) max_held = held;
      end
      b.count = held[CNT_W-1:0];
      if (keep) expected_beats.push_back(b);
    end else if (op == wsel_pkg::MODE_READ) begin
      readouts++;
      if (held == 0) begin
        b.status = wsel_pkg::STATUS_EMPTY;
        if (keep) expected_beats.push_back(b);
      end else if (keep) begin
        for (int i = 0; i < held; i++) begin
          b.weight = edge_w[i];
          b.dest   = edge_v[i];
          b.count  = held[CNT_W-1:0];
          b.last   = (i == held - 1);
          expected_beats.push_back(b);
        end
      end
    end else begin
      if (op == wsel_pkg::MODE_CLEAR) held = 0;
      b.count = held[CNT_W-1:0];
      if (keep) expected_beats.push_back(b);
    end
  endfunction

  task automatic send_op(input logic [wsel_pkg::MODE_W-1:0] op,
                         input logic signed [wsel_pkg::WEIGHT_W-1:0] w,
                         input logic [DEST_W-1:0] v,
                         input bit fixed = 1'b0,
                         input logic [CNT_W-1:0] fix_count = '0,
                         input logic [wsel_pkg::STATUS_W-1:0] fix_status =
                           wsel_pkg::STATUS_OK);
    int gap;
    bit took;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= op;
    edge_weight <= w;
    dest_vertex <= v;
    // Everything is driven at the rising edge, so the handshake is settled
    // by the falling edge before the edge that takes the beat.
    do begin
      @(negedge clk);
      took = in_valid && !in_stall;
      if (took) begin
        apply_edge_op(op, w, v, !fixed);
        if (fixed)
          expected_beats.push_back('{weight: '0, dest: '0, count: fix_count,
                                     status: fix_status, last: 1'b1});
      end
      @(posedge clk);
    end while (!took);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    list_beat_t seen;
    list_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{weight: out_weight, dest: out_dest, count: entry_count,
               status: status, last: last_of_run};
      @(posedge clk);
      beats_checked++;
      if (expected_beats.size() == 0) begin
        $error("output beat with nothing expected: weight %0d dest %0d count %0d status %0d",
               seen.weight, seen.dest, seen.count, seen.status);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("out_weight", int'(want.weight), int'(seen.weight));
        check_field("out_dest", int'(want.dest), int'(seen.dest));
        check_field("entry_count", int'(want.count), int'(seen.count));
        check_field("status", int'(want.status), int'(seen.status));
        check_field("last_of_run", int'(want.last), int'(seen.last));
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    recv_calm = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        // Long hold-off so the list output backs up and stalls the input.
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_holds++;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap(recv_calm);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    int kind;
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = wsel_pkg::MODE_SORTED;
    edge_weight  = '0;
    dest_vertex  = '0;
    held         = 0;
    errors       = 0;
    ops_sent     = 0;
    beats_checked = 0;
    full_hits    = 0;
    readouts     = 0;
    max_held     = 0;
    long_holds   = 0;
    cycle_count  = 0;
    send_calm    = 0;
    hold_request = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_op(dir_rows[i].op, dir_rows[i].w, dir_rows[i].v,
              dir_rows[i].fixed, dir_rows[i].cnt, dir_rows[i].st);

    // Fill the list past capacity, with a long output hold-off requested at the start.
    hold_request = 1'b1;
    send_op(wsel_pkg::MODE_CLEAR, pick_weight(), DEST_W'($urandom));
    while (full_hits < 2)
      send_op(pick_insert_mode(), pick_weight(), DEST_W'($urandom));
    send_op(wsel_pkg::MODE_READ, pick_weight(), DEST_W'($urandom));

    while (ops_sent < TOTAL_OPS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        repeat ($urandom_range(1, 8))
          send_op(pick_insert_mode(), pick_weight(), DEST_W'($urandom));
        send_op(wsel_pkg::MODE_READ, 16'($urandom), DEST_W'($urandom));
        if ($urandom_range(0, 3) == 0)
          send_op(wsel_pkg::MODE_CLEAR, 16'($urandom), DEST_W'($urandom));
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4))
          send_op(wsel_pkg::MODE_W'($urandom), 16'($urandom), DEST_W'($urandom));
      end else begin
        send_op(wsel_pkg::MODE_READ, pick_weight(), DEST_W'($urandom));
        send_op(wsel_pkg::MODE_CLEAR, pick_weight(), DEST_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d list operations and %0d output beats, %0d of them read-outs.",
             ops_sent, beats_checked, readouts);
    $display("Inserts into a full list: %0d, longest list: %0d, long receiver hold-offs: %0d.",
             full_hits, max_held, long_holds);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wsel_pkg.sv
hw/rtl/wsel_cell.sv
hw/rtl/weight_sorted_edge_list.sv
verif/weight_sorted_edge_list_tb.sv
